// ===== sv/b2s_pkg.sv =====
// Shared types, constants and helpers for the binary to seven-segment digit unit.
// No dependencies.
package b2s_pkg;

  localparam int unsigned VALUE_W = 63;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned PLACE_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Per-cycle command to the row of digit cells
  typedef struct packed {
    logic clear;
    logic conv;
    logic emit;
  } cell_ctrl_t;

  // Segment order a..g in bits 6..0
  localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
    7'b1111110, 7'b0110000, 7'b1101101, 7'b1111001, 7'b0110011,
    7'b1011011, 7'b0011111, 7'b1110000, 7'b1111111, 7'b1110011
  };

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = SEG_TABLE[0];
      4'd1: s = SEG_TABLE[1];
      4'd2: s = SEG_TABLE[2];
      4'd3: s = SEG_TABLE[3];
      4'd4: s = SEG_TABLE[4];
      4'd5: s = SEG_TABLE[5];
      4'd6: s = SEG_TABLE[6];
      4'd7: s = SEG_TABLE[7];
      4'd8: s = SEG_TABLE[8];
      4'd9: s = SEG_TABLE[9];
      default: s = '0;
    endcase
    return s;
  endfunction

  // Decimal digit count of the largest value of the given bit width (elaboration only)
  function automatic int unsigned num_digits(input int unsigned bits);
    logic [63:0]  v;
    int unsigned  n;
    v = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - bits);
    n = 0;
    while (v != 64'd0) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

endpackage

// ===== sv/b2s_cell.sv =====
// One BCD digit cell of the double-dabble row.
// Depends on b2s_pkg.
module b2s_cell (
  input  logic                           clk_i,
  input  b2s_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           bit_i,
  input  logic [b2s_pkg::DIGIT_W-1:0]    dig_i,
  output logic                           bit_o,
  output logic [b2s_pkg::DIGIT_W-1:0]    digit_o
);

  logic [b2s_pkg::DIGIT_W-1:0] digit_q, digit_d, adj;

  // add-3 when >= 5 so the shift carries into the next decade
  assign adj   = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign bit_o = adj[3];

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.emit) begin
      digit_d = dig_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// ===== sv/b2s_ctrl.sv =====
// Sequencer: serializes the value into the cell row, then steps the digits out.
// Depends on b2s_pkg.
module b2s_ctrl #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  logic                          rest_zero_i,
  output logic                          busy_o,
  output b2s_pkg::cell_ctrl_t           cell_ctrl_o,
  output logic                          serial_bit_o,
  output logic                          digit_valid_o,
  output logic [b2s_pkg::PLACE_W-1:0]   place_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  b2s_pkg::state_e              state_q, state_d;
  logic [VALUE_BITS-1:0]        shreg_q, shreg_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [b2s_pkg::PLACE_W-1:0]  place_q, place_d;
  logic                         accept;

  assign accept = start_i && (state_q == b2s_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      b2s_pkg::ST_IDLE: if (start_i) state_d = b2s_pkg::ST_CONV;
      b2s_pkg::ST_CONV: if (cnt_q == '0) state_d = b2s_pkg::ST_EMIT;
      b2s_pkg::ST_EMIT: if (rest_zero_i) state_d = b2s_pkg::ST_IDLE;
      default:          state_d = b2s_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    shreg_d     = shreg_q;
    cnt_d       = cnt_q;
    place_d     = place_q;
    cell_ctrl_o = '0;
    case (state_q)
      b2s_pkg::ST_IDLE: begin
        if (accept) begin
          shreg_d           = value_i;
          cnt_d             = CNT_W'(VALUE_BITS - 1);
          place_d           = '0;
          cell_ctrl_o.clear = 1'b1;
        end
      end
      b2s_pkg::ST_CONV: begin
        shreg_d          = shreg_q << 1;
        cnt_d            = cnt_q - 1'b1;
        cell_ctrl_o.conv = 1'b1;
      end
      b2s_pkg::ST_EMIT: begin
        place_d          = place_q + 1'b1;
        cell_ctrl_o.emit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b2s_pkg::ST_IDLE;
      cnt_q   <= '0;
      place_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      place_q <= place_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
  end

  assign serial_bit_o  = shreg_q[VALUE_BITS-1];
  assign busy_o        = (state_q != b2s_pkg::ST_IDLE);
  assign digit_valid_o = (state_q == b2s_pkg::ST_EMIT);
  assign place_o       = place_q;

endmodule

// ===== sv/binary_to_seven_segment_digits_unit.sv =====
// Top level: binary value in, decimal digits with segment patterns out, LSD first.
// Depends on b2s_pkg, b2s_cell, b2s_ctrl.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | start, busy            | value_i
//  result   | digit_valid_o (strobe) | digit_value_o, segments_o, place_o, last_digit_o
//
// An item runs as a load, then one double-dabble shift per value bit through the digit cell
// row, then one beat per decimal digit (1..19 digits) as the row shifts down toward
// cell 0.
// busy stays high from acceptance through the last beat; the next item can start
// the cycle after. Results cannot be stalled. Reset clears the sequencer only.
module binary_to_seven_segment_digits_unit #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [b2s_pkg::VALUE_W-1:0]   value_i,
  output logic                          digit_valid_o,
  output logic [b2s_pkg::DIGIT_W-1:0]   digit_value_o,
  output logic [b2s_pkg::SEG_W-1:0]     segments_o,
  output logic [b2s_pkg::PLACE_W-1:0]   place_o,
  output logic                          last_digit_o
);

  localparam int unsigned NDIG = b2s_pkg::num_digits(VALUE_BITS);

  b2s_pkg::cell_ctrl_t          cell_ctrl;
  logic                         serial_bit;
  logic                         rest_zero;
  logic [NDIG:0]                carry;
  logic [b2s_pkg::DIGIT_W-1:0]  digits [NDIG];
  logic [b2s_pkg::DIGIT_W-1:0]  upper  [NDIG];

  b2s_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .value_i       (value_i[VALUE_BITS-1:0]),
    .rest_zero_i   (rest_zero),
    .busy_o        (busy),
    .cell_ctrl_o   (cell_ctrl),
    .serial_bit_o  (serial_bit),
    .digit_valid_o (digit_valid_o),
    .place_o       (place_o)
  );

  assign carry[0] = serial_bit;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == NDIG - 1) begin : g_top
      assign upper[i] = '0;
    end else begin : g_mid
      assign upper[i] = digits[i+1];
    end
    b2s_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (carry[i]),
      .dig_i   (upper[i]),
      .bit_o   (carry[i+1]),
      .digit_o (digits[i])
    );
  end

  // carry[NDIG] is zero during the conversion shifts: the row is sized for the largest value
  always_comb begin
    rest_zero = ~carry[NDIG];
    for (int i = 1; i < NDIG; i++) begin
      rest_zero = rest_zero & (digits[i] == '0);
    end
  end

  assign digit_value_o = digits[0];
  assign segments_o    = b2s_pkg::seg_of(digits[0]);
  assign last_digit_o  = digit_valid_o & rest_zero;

  a_beat_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> busy)
    else $error("result beat outside a busy run");

  a_decimal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> (digit_value_o <= 4'd9))
    else $error("digit out of decimal range");

  a_run_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && last_digit_o) |=> !digit_valid_o && !busy)
    else $error("run continued after last digit");

  a_place_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && !last_digit_o) |=>
      digit_valid_o && (place_o == $past(place_o) + 5'd1))
    else $error("digit run broken or place skipped");

endmodule
